[rtl/core/skms_pkg.sv]
// ----------------------------------------------------------------------------
// skms_pkg
// Shared types and constants for the shift register key matrix scanner.
// ----------------------------------------------------------------------------
package skms_pkg;

  localparam int MAX_KEYS      = 32;
  localparam int MAX_CHIPS     = 4;
  localparam int BITS_PER_CHIP = 8;

  localparam int KEY_W   = 5;
  localparam int COUNT_W = 6;
  localparam int CHIPS_W = 3;
  localparam int WORD_W  = MAX_CHIPS * BITS_PER_CHIP;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_TRUE        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECT_PIN_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHIP_COUNT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHIP_BYTE_ORDER = 3'd4;

  // Reset values
  localparam logic [COUNT_W-1:0] KEY_COUNT_RST  = 6'd32;
  localparam logic [CHIPS_W-1:0] CHIP_COUNT_RST = 3'd4;
  localparam logic [CFG_W-1:0]   BYTE_ORDER_RST = 8'd228;
  localparam logic [MAX_KEYS-1:0] FRAME_RST     = 32'hFFFF_FFFF;

  // Result kinds
  localparam logic KIND_DRIVE = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRIVE,
    ST_SEEK,
    ST_EMIT
  } skms_state_t;

  typedef struct packed {
    logic accept;      // take the input transaction and build the drive result
    logic load_event;  // load an event result and step the change scan
    logic advance;     // step the change scan without a result
  } skms_cmd_t;

  typedef struct packed {
    logic has_events;  // the last tick closed a frame with changed keys
    logic evt_bit;     // key under the scan has changed
    logic evt_last;    // no changed key beyond the one under the scan
    logic evt_none;    // no changed key left in the scan
  } skms_status_t;

endpackage

[rtl/core/skms_ctrl.sv]
// ----------------------------------------------------------------------------
// skms_ctrl
// Sequencer: accepts a tick, presents its drive result, then at a frame close
// with changed keys walks the changed-key word, presenting one event each.
// ----------------------------------------------------------------------------
module skms_ctrl
  import skms_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  skms_status_t status,
  output skms_cmd_t    cmd
);

  skms_state_t state;
  skms_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DRIVE;
      end
      ST_DRIVE: begin
        if (!out_stall) state_next = status.has_events ? ST_SEEK : ST_IDLE;
      end
      ST_SEEK: begin
        if (status.evt_bit) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall) state_next = status.evt_none ? ST_IDLE : ST_SEEK;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    in_stall       = 1'b1;
    out_valid      = 1'b0;
    cmd.accept     = 1'b0;
    cmd.load_event = 1'b0;
    cmd.advance    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_DRIVE: out_valid = 1'b1;
      ST_SEEK: begin
        cmd.load_event = status.evt_bit;
        cmd.advance    = !status.evt_bit;
      end
      ST_EMIT: out_valid = 1'b1;
      default: in_stall = 1'b1;
    endcase
  end

endmodule

[rtl/core/skms_datapath.sv]
// ----------------------------------------------------------------------------
// skms_datapath
// Configuration registers, scan position, frame words, change scan and the
// result register.
// ----------------------------------------------------------------------------
module skms_datapath
  import skms_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  input  logic [KEY_W-1:0]     slot_number,
  input  logic                 pin_level,
  input  skms_cmd_t            cmd,
  output skms_status_t         status,
  output logic                 kind,
  output logic [WORD_W-1:0]    drive_word,
  output logic [KEY_W-1:0]     key_index,
  output logic                 pressed,
  output logic                 last_of_run
);

  // Configuration
  logic [COUNT_W-1:0] key_count;
  logic               low_true;
  logic               direct_pin_mode;
  logic [CHIPS_W-1:0] chip_count;
  logic [CFG_W-1:0]   chip_byte_order;

  // Scan state
  logic [KEY_W-1:0]    scan_position;
  logic                frame_started;
  logic [MAX_KEYS-1:0] frame_bits;
  logic [MAX_KEYS-1:0] previous_frame_bits;

  // Change scan
  logic [MAX_KEYS-1:0] evt_bits;
  logic [MAX_KEYS-1:0] press_bits;
  logic [KEY_W-1:0]    evt_index;
  logic                has_events;

  // Tick arithmetic
  logic [COUNT_W-1:0]  eff_keys;
  logic [CHIPS_W-1:0]  eff_chips;
  logic [KEY_W-1:0]    pos;
  logic [COUNT_W-1:0]  pos_inc;
  logic [KEY_W-1:0]    next_pos;
  logic [MAX_KEYS-1:0] sample_bit;
  logic [MAX_KEYS-1:0] key_mask;
  logic [MAX_KEYS-1:0] pattern;
  logic [WORD_W-1:0]   drive_calc;
  logic                close_frame;
  logic [MAX_KEYS-1:0] closed_frame;
  logic [MAX_KEYS-1:0] changed;

  // Clamp the register values to their usable ranges
  always_comb begin
    if (key_count == '0) begin
      eff_keys = COUNT_W'(1);
    end else if (key_count > COUNT_W'(MAX_KEYS)) begin
      eff_keys = COUNT_W'(MAX_KEYS);
    end else begin
      eff_keys = key_count;
    end
    eff_chips = (chip_count > CHIPS_W'(MAX_CHIPS)) ? CHIPS_W'(MAX_CHIPS) : chip_count;
  end

  // Sample position, wrapped next position and the sampled key bit
  always_comb begin
    pos        = ({1'b0, scan_position} >= eff_keys) ? '0 : scan_position;
    pos_inc    = {1'b0, pos} + COUNT_W'(1);
    next_pos   = (pos_inc >= eff_keys) ? '0 : pos_inc[KEY_W-1:0];
    sample_bit = MAX_KEYS'(pin_level ^ low_true) << pos;
    key_mask   = ~({MAX_KEYS{1'b1}} << eff_keys);
  end

  // Build the drive word for the next position (all zeros in direct pin mode)
  always_comb begin
    pattern    = MAX_KEYS'(1) << next_pos;
    drive_calc = '0;
    if (low_true) pattern = ~pattern;
    for (int i = 0; i < MAX_CHIPS; i++) begin
      if (CHIPS_W'(i) < eff_chips) begin
        drive_calc[i*BITS_PER_CHIP +: BITS_PER_CHIP] =
          pattern[{chip_byte_order[2*i +: 2], 3'b000} +: BITS_PER_CHIP];
      end
    end
    if (direct_pin_mode) drive_calc = '0;
  end

  // Frame close and the changed-key word
  always_comb begin
    close_frame  = frame_started && ({1'b0, slot_number} == eff_keys - COUNT_W'(1));
    closed_frame = frame_bits | sample_bit;
    changed      = (previous_frame_bits ^ closed_frame) & key_mask;
  end

  assign status.has_events = has_events;
  assign status.evt_bit    = evt_bits[0];
  assign status.evt_last   = (evt_bits[MAX_KEYS-1:1] == '0);
  assign status.evt_none   = (evt_bits == '0);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count       <= KEY_COUNT_RST;
      low_true        <= 1'b0;
      direct_pin_mode <= 1'b0;
      chip_count      <= CHIP_COUNT_RST;
      chip_byte_order <= BYTE_ORDER_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_KEY_COUNT:       key_count       <= cfg_wr_data[COUNT_W-1:0];
        REG_LOW_TRUE:        low_true        <= cfg_wr_data[0];
        REG_DIRECT_PIN_MODE: direct_pin_mode <= cfg_wr_data[0];
        REG_CHIP_COUNT:      chip_count      <= cfg_wr_data[CHIPS_W-1:0];
        REG_CHIP_BYTE_ORDER: chip_byte_order <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Advance the scan and frame state on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_position       <= '0;
      frame_started       <= 1'b0;
      frame_bits          <= FRAME_RST;
      previous_frame_bits <= '0;
      has_events          <= 1'b0;
    end else if (cmd.accept) begin
      scan_position <= next_pos;
      has_events    <= 1'b0;
      if (!frame_started) begin
        if (slot_number == '0) begin
          frame_started <= 1'b1;
          frame_bits    <= closed_frame;
        end
      end else if (close_frame) begin
        previous_frame_bits <= closed_frame;
        frame_bits          <= '0;
        frame_started       <= 1'b0;
        has_events          <= (changed != '0);
      end else begin
        frame_bits <= closed_frame;
      end
    end
  end

  // Change scan: shift one key per step
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      evt_bits   <= changed;
      press_bits <= closed_frame;
      evt_index  <= '0;
    end else if (cmd.load_event || cmd.advance) begin
      evt_bits   <= evt_bits >> 1;
      press_bits <= press_bits >> 1;
      evt_index  <= evt_index + KEY_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind        <= KIND_DRIVE;
      drive_word  <= drive_calc;
      key_index   <= '0;
      pressed     <= 1'b0;
      last_of_run <= !(close_frame && (changed != '0));
    end else if (cmd.load_event) begin
      kind        <= KIND_EVENT;
      drive_word  <= '0;
      key_index   <= evt_index;
      pressed     <= press_bits[0];
      last_of_run <= status.evt_last;
    end
  end

endmodule

[rtl/core/shift_register_key_matrix_scanner.sv]
// ----------------------------------------------------------------------------
// shift_register_key_matrix_scanner
// Key matrix scanner with change detection for cascaded shift-chip drive.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one scan tick: slot_number
//   and the sampled pin_level for the current scan position.
//   Output channel (out_valid / out_stall) returns the results of a tick:
//   first the drive word for the next position, then at a frame close one
//   event per changed key in increasing key order. last_of_run marks the
//   final result of each tick.
//   Configuration is written through cfg_wr_en / cfg_index / cfg_wr_data
//   while the block is idle.
// Sequencing:
//   The drive result is presented in the cycle after the tick is accepted.
//   A tick with no events ends with that result. At a frame close the
//   change scan then steps through one key per cycle, pausing at each
//   changed key until its event has left. One tick is in flight at a time.
// Reset (rst, synchronous): scan position 0, no frame open, frame word all
//   ones, previous frame zero, configuration at its defaults.
// Stalls: a result is held unchanged while out_stall is high, and no new
//   transaction is taken until the last result of the tick has left.
// ----------------------------------------------------------------------------
module shift_register_key_matrix_scanner
  import skms_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [KEY_W-1:0]     slot_number,
  input  logic                 pin_level,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 kind,
  output logic [WORD_W-1:0]    drive_word,
  output logic [KEY_W-1:0]     key_index,
  output logic                 pressed,
  output logic                 last_of_run
);

  skms_cmd_t    cmd;
  skms_status_t status;

  // Sequencer
  skms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Scan state, change scan and result register
  skms_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .slot_number (slot_number),
    .pin_level   (pin_level),
    .cmd         (cmd),
    .status      (status),
    .kind        (kind),
    .drive_word  (drive_word),
    .key_index   (key_index),
    .pressed     (pressed),
    .last_of_run (last_of_run)
  );

endmodule

[rtl/core/skms_checker.sv]
// ----------------------------------------------------------------------------
// skms_checker
// Port-level checks on the scanner's transaction sequencing.
// ----------------------------------------------------------------------------
module skms_checker
  import skms_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              kind,
  input logic [WORD_W-1:0] drive_word,
  input logic              last_of_run
);

  // Every accepted tick answers with its drive result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (out_valid && kind == KIND_DRIVE))
    else $error("accepted tick not followed by a drive result");

  // No new tick is taken while a result waits
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  // A run that is not finished keeps the input closed
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_of_run) |=> in_stall)
    else $error("input reopened before the last result of a tick");

  // Events carry no drive word
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_EVENT) |-> (drive_word == '0))
    else $error("event result with a non-zero drive word");

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(drive_word) && $stable(kind)))
    else $error("stalled result changed");

endmodule

bind shift_register_key_matrix_scanner skms_checker u_skms_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .kind        (kind),
  .drive_word  (drive_word),
  .last_of_run (last_of_run)
);
